@@ hw/rtl/lcwd_pkg.sv @@
// Shared types and constants for the LCW (format80) decompressor.
// Used by lcw_decompressor_unit; no dependencies.
package lcwd_pkg;

  // History memory size
  localparam int HISTORY_BITS = 16;
  localparam int HIST_DEPTH   = 1 << HISTORY_BITS;

  // Result queue depth (covers the RAM read stage plus one waiting result)
  localparam int Q_DEPTH = 3;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command codes and field masks
  localparam logic [7:0] CMD_END       = 8'h80;
  localparam logic [7:0] CMD_FILL      = 8'hFE;
  localparam logic [7:0] CMD_LONG      = 8'hFF;
  localparam logic [7:0] CMD_ABS_BIT   = 8'h40;
  localparam logic [7:0] CMD_CNT_MASK  = 8'h3F;
  localparam logic [7:0] CMD_DIST_MASK = 8'h0F;

  typedef enum logic [3:0] {
    PH_CMD     = 4'd0,
    PH_REL_OFF = 4'd1,
    PH_LIT     = 4'd2,
    PH_FILL_C0 = 4'd3,
    PH_FILL_C1 = 4'd4,
    PH_FILL_V  = 4'd5,
    PH_LONG_C0 = 4'd6,
    PH_LONG_C1 = 4'd7,
    PH_ABS_O0  = 4'd8,
    PH_ABS_O1  = 4'd9,
    PH_COPY    = 4'd10,
    PH_FILL    = 4'd11
  } lcwd_phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } lcwd_in_t;

  typedef struct packed {
    logic        byte_taken;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        finished;
    logic [15:0] total_length;
  } lcwd_out_t;

  // Control carried from the decode stage to the history read stage
  typedef struct packed {
    logic                    is_copy;
    logic                    fwd;
    logic                    wr;
    logic [HISTORY_BITS-1:0] waddr;
  } lcwd_s1_ctl_t;

endpackage

@@ hw/rtl/lcwd_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read, read-before-write. No dependencies.
module lcwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/lcw_decompressor_unit.sv @@
// LCW (format80) stream decompressor, top level.
// Depends on lcwd_pkg and lcwd_ram (history memory).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one step per transfer.
//   in_data.mode = 1 offers a compressed byte, mode = 0 asks for an emit step.
//   Output channel (out_valid / out_stall / out_data): exactly one result per
//   input transfer, in order, with byte_taken, the decoded byte, and on the
//   end command finished plus the saturated frame length.
//   Pipeline: the history read and the read stage registers take a step at
//   its input transfer edge, and its result is written into the result queue
//   at the next edge and presented from there.
//   Throughput: one transfer per cycle while in_stall is low. Copies read and write the 64 KB
//   history memory once per step; a read of the entry written by the step
//   just before is forwarded from a register, so overlapping copies run at
//   full rate.
//   A 3-entry result queue follows the memory read stage; in_stall rises
//   when queued plus in-flight results already fill it, so a stalled receiver
//   backs up into the input channel without losing a result.
//   Reset (rst_n low, synchronous) clears the decoder to await a command at
//   frame position zero and empties the pipeline. The history memory is not
//   cleared; copies must only reference bytes already decoded.
module lcw_decompressor_unit
  import lcwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lcwd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lcwd_out_t out_data
);

  // Decoder state
  lcwd_phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [15:0] wpos_r, wpos_nxt;
  logic [15:0] flen_r, flen_nxt;

  // Read stage
  logic         s1_vld_r;
  lcwd_s1_ctl_t s1_ctl_r, s1_ctl_nxt;
  lcwd_out_t    s1_res_r, s1_res_nxt;
  logic [7:0]   fwd_byte_r;
  logic [7:0]   s1_byte;
  logic [7:0]   ram_rdata;
  logic         copy_rd;
  logic [HISTORY_BITS-1:0] rd_addr;

  // Result queue
  lcwd_out_t          q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] q_wr_ptr_r, q_rd_ptr_r;
  logic [Q_CNT_W-1:0] q_cnt_r;
  logic               q_push, q_pop;
  lcwd_out_t          q_wdata;

  logic       accept;
  logic [7:0] b;
  logic [15:0] back_dist;

  // Hold input while queued plus in-flight results would overflow the queue
  assign in_stall  = ({1'b0, q_cnt_r} + {{Q_CNT_W{1'b0}}, s1_vld_r}) >=
                     (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept    = in_valid && !in_stall;
  assign b         = in_data.in_byte;
  assign back_dist = {4'h0, cmd_r[3:0] & CMD_DIST_MASK[3:0], b};
  assign rd_addr   = src_r[HISTORY_BITS-1:0];

  // Decode one step: next state and the partial result
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    rem_nxt    = rem_r;
    src_nxt    = src_r;
    fill_nxt   = fill_r;
    wpos_nxt   = wpos_r;
    flen_nxt   = flen_r;
    s1_res_nxt = '0;
    s1_ctl_nxt = '0;
    copy_rd    = 1'b0;
    s1_ctl_nxt.waddr = wpos_r[HISTORY_BITS-1:0];

    if (accept) begin
      if (phase_r == PH_COPY || phase_r == PH_FILL) begin
        // Emit one byte from history or the fill value
        s1_res_nxt.out_valid = 1'b1;
        s1_ctl_nxt.wr        = 1'b1;
        if (phase_r == PH_COPY) begin
          copy_rd            = 1'b1;
          s1_ctl_nxt.is_copy = 1'b1;
          src_nxt            = src_r + 16'd1;
        end else begin
          s1_res_nxt.out_byte = fill_r;
        end
      end else if (in_data.mode) begin
        s1_res_nxt.byte_taken = 1'b1;
        unique case (phase_r)
          PH_REL_OFF: begin
            src_nxt   = wpos_r - back_dist;
            phase_nxt = PH_COPY;
          end
          PH_LIT: begin
            s1_res_nxt.out_valid = 1'b1;
            s1_res_nxt.out_byte  = b;
            s1_ctl_nxt.wr        = 1'b1;
          end
          PH_FILL_C0: begin
            rem_nxt   = {8'h00, b};
            phase_nxt = PH_FILL_C1;
          end
          PH_FILL_C1: begin
            rem_nxt   = {b, rem_r[7:0]};
            phase_nxt = PH_FILL_V;
          end
          PH_FILL_V: begin
            fill_nxt  = b;
            phase_nxt = (rem_r != 16'd0) ? PH_FILL : PH_CMD;
          end
          PH_LONG_C0: begin
            rem_nxt   = {8'h00, b};
            phase_nxt = PH_LONG_C1;
          end
          PH_LONG_C1: begin
            rem_nxt   = {b, rem_r[7:0]};
            phase_nxt = PH_ABS_O0;
          end
          PH_ABS_O0: begin
            src_nxt   = {8'h00, b};
            phase_nxt = PH_ABS_O1;
          end
          PH_ABS_O1: begin
            src_nxt   = {b, src_r[7:0]};
            phase_nxt = (rem_r != 16'd0) ? PH_COPY : PH_CMD;
          end
          default: begin
            // Command byte (unused codes decode as a command too)
            cmd_nxt = b;
            if (!b[7]) begin
              rem_nxt   = {12'h000, b[7:4]} + 16'd3;
              phase_nxt = PH_REL_OFF;
            end else if (b == CMD_END) begin
              wpos_nxt                = 16'd0;
              flen_nxt                = 16'd0;
              phase_nxt               = PH_CMD;
              s1_res_nxt.finished     = 1'b1;
              s1_res_nxt.total_length = flen_r;
            end else if (b == CMD_FILL) begin
              phase_nxt = PH_FILL_C0;
            end else if (b == CMD_LONG) begin
              phase_nxt = PH_LONG_C0;
            end else if ((b & CMD_ABS_BIT) != 8'h00) begin
              rem_nxt   = {8'h00, b & CMD_CNT_MASK} + 16'd3;
              phase_nxt = PH_ABS_O0;
            end else begin
              rem_nxt   = {8'h00, b & CMD_CNT_MASK};
              phase_nxt = ((b & CMD_CNT_MASK) != 8'h00) ? PH_LIT : PH_CMD;
            end
          end
        endcase
      end

      // Advance position and counters for an emitted byte
      if (s1_ctl_nxt.wr) begin
        wpos_nxt = wpos_r + 16'd1;
        if (flen_r != 16'hFFFF) begin
          flen_nxt = flen_r + 16'd1;
        end
        rem_nxt = rem_r - 16'd1;
        if (rem_r == 16'd1) begin
          phase_nxt = PH_CMD;
        end
      end
    end

    // Forward when the read hits the entry being written this cycle
    s1_ctl_nxt.fwd = copy_rd && s1_vld_r && s1_ctl_r.wr &&
                     (s1_ctl_r.waddr == rd_addr);
  end

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      cmd_r   <= '0;
      rem_r   <= '0;
      src_r   <= '0;
      fill_r  <= '0;
      wpos_r  <= '0;
      flen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      rem_r   <= rem_nxt;
      src_r   <= src_nxt;
      fill_r  <= fill_nxt;
      wpos_r  <= wpos_nxt;
      flen_r  <= flen_nxt;
    end
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_ctl_r <= s1_ctl_nxt;
    s1_res_r <= s1_res_nxt;
    if (s1_vld_r && s1_ctl_r.wr) begin
      fwd_byte_r <= s1_byte;
    end
  end

  // History memory
  lcwd_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (s1_vld_r && s1_ctl_r.wr),
    .wr_addr (s1_ctl_r.waddr),
    .wr_data (s1_byte),
    .rd_en   (copy_rd),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // Resolve the decoded byte
  always_comb begin
    if (s1_ctl_r.is_copy) begin
      s1_byte = s1_ctl_r.fwd ? fwd_byte_r : ram_rdata;
    end else begin
      s1_byte = s1_res_r.out_byte;
    end
    q_wdata          = s1_res_r;
    q_wdata.out_byte = s1_byte;
  end

  // Result queue
  assign q_push    = s1_vld_r;
  assign out_valid = (q_cnt_r != '0);
  assign q_pop     = out_valid && !out_stall;
  assign out_data  = q_mem_r[q_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= '0;
      q_rd_ptr_r <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr_r <= (q_wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
                      q_wr_ptr_r + Q_PTR_W'(1);
      end
      if (q_pop) begin
        q_rd_ptr_r <= (q_rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
                      q_rd_ptr_r + Q_PTR_W'(1);
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + Q_CNT_W'(1);
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - Q_CNT_W'(1);
      end
    end
    if (q_push) begin
      q_mem_r[q_wr_ptr_r] <= q_wdata;
    end
  end

endmodule
